// ----- design/albe_pkg.sv -----
// shared types and constants of the addressable led bit encoder
package albe_pkg;

  localparam int GammaEntries = 256;
  localparam int GammaW       = 8;
  localparam int GammaAddrW   = $clog2(GammaEntries);
  localparam int BitsPerPixel = 24;
  localparam int SegsPerPixel = 2 * BitsPerPixel;
  localparam int SegCntW      = $clog2(SegsPerPixel);
  localparam int TickW        = 10;
  localparam int DurW         = 16;
  localparam int PixCntW      = 11;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;

  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_TABLE = 2'd1;
  localparam logic [1:0] CMD_EOF   = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ONE_LOW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RESET      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GAMMA_EN   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MAX_PIXELS = 3'd6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } item_t;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] duration;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [TickW-1:0]   one_high_ticks;
    logic [TickW-1:0]   one_low_ticks;
    logic [TickW-1:0]   zero_high_ticks;
    logic [TickW-1:0]   zero_low_ticks;
    logic [DurW-1:0]    reset_ticks;
    logic               gamma_enable;
    logic [PixCntW-1:0] max_pixels;
  } cfg_t;

  typedef struct packed {
    logic                    eof;
    logic [BitsPerPixel-1:0] word;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     avail;
    q_entry_t head;
  } q_rd_t;

endpackage

// ----- design/albe_ram.sv -----
// generic single-port ram with registered read
module albe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- design/albe_front.sv -----
// front end: takes items, runs gamma lookups, counts pixels, queues work
module albe_front import albe_pkg::*; #(
  parameter int PIXEL_LIMIT = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  input  cfg_t  cfg,
  input  logic  q_full,
  output q_wr_t q_wr,
  output logic  busy
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_RED  = 4'b0010,
    F_BLUE = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t             state, state_next;
  logic [7:0]          grn_q, red_q, blue_q;
  logic [7:0]          g_val, r_val;
  logic [PixCntW-1:0]  pixel_count;
  logic [GammaEntries-1:0] gvld;
  logic                vld_q;
  logic                ram_we, ram_re;
  logic [GammaAddrW-1:0] ram_addr;
  logic [GammaW-1:0]   ram_q;
  logic                drop;
  logic [7:0]          b_look;

  function automatic logic [7:0] lookup(input logic en, input logic v,
                                        input logic [7:0] q, input logic [7:0] c);
    return (en && v) ? q : c;
  endfunction

  albe_ram #(.WIDTH(GammaW), .DEPTH(GammaEntries)) u_gamma (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (item.table_value),
    .rdata (ram_q)
  );

  // a frame holds at most the smaller of max_pixels and PIXEL_LIMIT
  assign drop = (pixel_count >= cfg.max_pixels) || (32'(pixel_count) >= PIXEL_LIMIT);
  assign b_look = lookup(cfg.gamma_enable, vld_q, ram_q, blue_q);
  assign busy = (state != F_IDLE);

  always_comb begin
    state_next         = state;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_addr           = item.green;
    q_wr.push          = 1'b0;
    q_wr.entry.eof     = 1'b0;
    q_wr.entry.word    = {g_val, r_val, b_look};
    case (state)
      F_IDLE: begin
        if (take) begin
          case (item.cmd)
            CMD_PIXEL: begin
              if (!drop) begin
                ram_re     = 1'b1;
                ram_addr   = item.green;
                state_next = F_RED;
              end
            end
            CMD_TABLE: begin
              ram_we   = 1'b1;
              ram_addr = item.table_index;
            end
            CMD_EOF: begin
              q_wr.push       = 1'b1;
              q_wr.entry.eof  = 1'b1;
              q_wr.entry.word = '0;
            end
            default: ;
          endcase
        end
      end
      F_RED: begin
        ram_re     = 1'b1;
        ram_addr   = red_q;
        state_next = F_BLUE;
      end
      F_BLUE: begin
        ram_re     = 1'b1;
        ram_addr   = blue_q;
        state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_wr.push  = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      pixel_count <= '0;
      gvld        <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && take) begin
        if (item.cmd == CMD_EOF) begin
          pixel_count <= '0;
        end else if (item.cmd == CMD_PIXEL && !drop) begin
          pixel_count <= pixel_count + 1'b1;
        end
      end
      if (ram_we) begin
        gvld[ram_addr] <= 1'b1;
      end
    end
  end

  // entries never written read as the identity
  always_ff @(posedge clk) begin
    if (ram_re) begin
      vld_q <= gvld[ram_addr];
    end
    if (state == F_IDLE && take) begin
      grn_q  <= item.green;
      red_q  <= item.red;
      blue_q <= item.blue;
    end
    if (state == F_RED) begin
      g_val <= lookup(cfg.gamma_enable, vld_q, ram_q, grn_q);
    end
    if (state == F_BLUE) begin
      r_val <= lookup(cfg.gamma_enable, vld_q, ram_q, red_q);
    end
  end

endmodule

// ----- design/albe_queue.sv -----
// short fall-through queue between front and back
module albe_queue import albe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  output logic  full,
  output q_rd_t rd,
  input  logic  take
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full     = (count == CntW'(DEPTH));
  assign rd.avail = (count != '0);
  assign rd.head  = mem[rptr];
  assign do_wr    = wr.push && !full;
  assign do_rd    = take && rd.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr.entry;
    end
  end

endmodule

// ----- design/albe_back.sv -----
// back end: turns queued pixels and frame ends into line segments
module albe_back import albe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  q_rd_t   q_rd,
  output logic    q_take,
  output logic    out_vld,
  output result_t out_seg,
  input  logic    out_pop
);

  q_entry_t           cur;
  logic               cur_vld;
  logic [SegCntW-1:0] cnt;
  result_t            seg;
  logic               seg_last;
  logic               adv;
  logic               bit_one;

  assign bit_one  = cur.word[BitsPerPixel-1];
  assign seg_last = cur.eof || (cnt == SegCntW'(SegsPerPixel - 1));
  assign adv      = cur_vld && (!out_vld || out_pop);
  assign q_take   = q_rd.avail && (!cur_vld || (adv && seg_last));

  always_comb begin
    if (cur.eof) begin
      seg.level    = 1'b0;
      seg.duration = cfg.reset_ticks;
      seg.last     = 1'b1;
    end else begin
      // even count: high half of the bit, odd count: low half
      seg.level = !cnt[0];
      if (cnt[0]) begin
        seg.duration = DurW'(bit_one ? cfg.one_low_ticks : cfg.zero_low_ticks);
      end else begin
        seg.duration = DurW'(bit_one ? cfg.one_high_ticks : cfg.zero_high_ticks);
      end
      seg.last = seg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (adv) begin
        out_vld <= 1'b1;
      end else if (out_pop) begin
        out_vld <= 1'b0;
      end
      if (q_take) begin
        cur_vld <= 1'b1;
      end else if (adv && seg_last) begin
        cur_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_seg <= seg;
    end
    if (q_take) begin
      cur <= q_rd.head;
      cnt <= '0;
    end else if (adv) begin
      cnt <= cnt + 1'b1;
      if (cnt[0]) begin
        cur.word <= {cur.word[BitsPerPixel-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- design/addressable_led_bit_encoder_unit.sv -----
// top level of the addressable led bit encoder
// a pixel gives 48 segments, one per cycle from the back-end sequencer unless pop stalls it
// front steps F_RED, F_BLUE, F_PUSH per pixel: three lookups through the single gamma ram port
// pixel path: front states, queue, cur, out_seg to result; a frame end skips the front states
// table writes and dropped pixels stay in F_IDLE and give no result
// rst resets config, state and counts; gamma valid bits clear so the table reads as identity
module addressable_led_bit_encoder_unit import albe_pkg::*; #(
  parameter int PIXEL_LIMIT = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  output logic                empty,
  input  logic                pop,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full, q_take, front_busy, take, out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high_ticks  <= TickW'(80);
      cfg.one_low_ticks   <= TickW'(45);
      cfg.zero_high_ticks <= TickW'(40);
      cfg.zero_low_ticks  <= TickW'(85);
      cfg.reset_ticks     <= DurW'(6000);
      cfg.gamma_enable    <= 1'b1;
      cfg.max_pixels      <= PixCntW'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONE_HIGH:   cfg.one_high_ticks  <= cfg_data[TickW-1:0];
        REG_ONE_LOW:    cfg.one_low_ticks   <= cfg_data[TickW-1:0];
        REG_ZERO_HIGH:  cfg.zero_high_ticks <= cfg_data[TickW-1:0];
        REG_ZERO_LOW:   cfg.zero_low_ticks  <= cfg_data[TickW-1:0];
        REG_RESET:      cfg.reset_ticks     <= cfg_data[DurW-1:0];
        REG_GAMMA_EN:   cfg.gamma_enable    <= cfg_data[0];
        REG_MAX_PIXELS: cfg.max_pixels      <= cfg_data[PixCntW-1:0];
        default: ;
      endcase
    end
  end

  assign full  = front_busy || q_full;
  assign take  = push && !full;
  assign empty = !out_vld;

  albe_front #(.PIXEL_LIMIT(PIXEL_LIMIT)) u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .cfg    (cfg),
    .q_full (q_full),
    .q_wr   (q_wr),
    .busy   (front_busy)
  );

  albe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .rd   (q_rd),
    .take (q_take)
  );

  albe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_rd    (q_rd),
    .q_take  (q_take),
    .out_vld (out_vld),
    .out_seg (result),
    .out_pop (pop)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_full)
    else $error("front pushed into a full queue");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    front_busy |-> full)
    else $error("input open while front is busy");

  a_high_never_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.level) |-> !result.last)
    else $error("high segment flagged as last");

  a_take_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_rd.avail)
    else $error("back took from an empty queue");
`endif

endmodule
